>>> src/fmprc_pkg.sv
// Shared types, constants and helper functions for the first-match rule classifier.
`timescale 1ns / 1ps
`default_nettype none

package fmprc_pkg;

    // Default size of the rule table.
    localparam int RULES_DEFAULT = 16;

    // Field widths fixed by the request and response formats.
    localparam int RULE_INDEX_W = 4;
    localparam int WORD_SEL_W   = 3;
    localparam int WORD_W       = 64;
    localparam int ACTION_W     = 2;
    localparam int COUNT_W      = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int CTRL_W       = 62;

    // Request modes.
    localparam logic MODE_CLASSIFY = 1'b0;
    localparam logic MODE_WRITE    = 1'b1;

    // Rule word selectors.
    localparam logic [WORD_SEL_W-1:0] WSEL_SRC_HI = 3'd0;
    localparam logic [WORD_SEL_W-1:0] WSEL_SRC_LO = 3'd1;
    localparam logic [WORD_SEL_W-1:0] WSEL_DST_HI = 3'd2;
    localparam logic [WORD_SEL_W-1:0] WSEL_DST_LO = 3'd3;
    localparam logic [WORD_SEL_W-1:0] WSEL_CTRL   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_RULE_COUNT     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_ACTION = 1'b1;

    // Rule family codes.
    localparam logic [1:0] FAM_ANY  = 2'd0;
    localparam logic [1:0] FAM_IPV4 = 2'd1;
    localparam logic [1:0] FAM_IPV6 = 2'd2;

    // IP version numbers.
    localparam logic [3:0] IP_VER_4 = 4'd4;
    localparam logic [3:0] IP_VER_6 = 4'd6;

    // Request payload.
    typedef struct packed {
        logic                    mode;
        logic [RULE_INDEX_W-1:0] rule_index;
        logic [WORD_SEL_W-1:0]   word_select;
        logic [WORD_W-1:0]       word_data;
        logic [3:0]              pkt_version;
        logic [7:0]              protocol;
        logic [WORD_W-1:0]       src_addr_hi;
        logic [WORD_W-1:0]       src_addr_lo;
        logic [WORD_W-1:0]       dst_addr_hi;
        logic [WORD_W-1:0]       dst_addr_lo;
        logic [15:0]             src_port_in;
        logic [15:0]             dst_port_in;
    } req_t;

    // Response payload.
    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic                    match_found;
        logic [RULE_INDEX_W-1:0] hit_index;
    } rsp_t;

    // One request travelling along the cell chain with its partial result.
    typedef struct packed {
        logic                    valid;
        req_t                    item;
        logic                    found;
        logic [ACTION_W-1:0]     action;
        logic [RULE_INDEX_W-1:0] index;
    } stage_t;

    // Mask with the top plen bits set; lengths past 128 saturate.
    function automatic logic [127:0] prefix_mask(input logic [7:0] plen);
        logic [127:0] mask;
        if (plen == 8'd0) begin
            mask = '0;
        end else if (plen[7]) begin
            mask = '1;
        end else begin
            mask = ~({128{1'b1}} >> plen[6:0]);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

>>> src/first_match_packet_rule_classifier.sv
// Top level: configuration registers and the chain of rule cells.
// A request passes through every cell's stage register from acceptance to the response.
// Throughput: one request per cycle while no response is held; each cell holds
// one rule and passes the request on as the chain moves; chain length sets latency.
// A stalled response freezes the whole chain and stalls new requests.
// Reset clears rule_count, default_action, every control word and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module first_match_packet_rule_classifier #(
    parameter int RULES = fmprc_pkg::RULES_DEFAULT
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              req_valid,
    output logic                             req_stall,
    input  fmprc_pkg::req_t                  req,
    output logic                             rsp_valid,
    input  wire                              rsp_stall,
    output fmprc_pkg::rsp_t                  rsp,
    input  wire                              cfg_we,
    input  wire [fmprc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [fmprc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fmprc_pkg::*;

    logic [COUNT_W-1:0]  rule_count_reg;
    logic [ACTION_W-1:0] default_action_reg;
    logic                advance;
    stage_t              seed;
    stage_t              chain_in  [RULES];
    stage_t              chain_out [RULES];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rule_count_reg     <= '0;
            default_action_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RULE_COUNT:
                begin
                    rule_count_reg <= cfg_data[COUNT_W-1:0];
                end
                CFG_DEFAULT_ACTION:
                begin
                    default_action_reg <= cfg_data[ACTION_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The chain moves unless a finished response is held at the end.
    assign advance   = !(rsp_valid && rsp_stall);
    assign req_stall = !advance;

    // A new request enters with the default result.
    always_comb
    begin
        seed.valid  = req_valid;
        seed.item   = req;
        seed.found  = 1'b0;
        seed.action = default_action_reg;
        seed.index  = '0;
    end

    // Row of rule cells.
    for (genvar g = 0; g < RULES; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign chain_in[g] = seed;
        end else begin : g_next
            assign chain_in[g] = chain_out[g-1];
        end

        fmprc_cell #(
            .CellId (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .rule_count (rule_count_reg),
            .stage_in   (chain_in[g]),
            .stage_out  (chain_out[g])
        );
    end

    // The last stage register is the response register; writes drop out here.
    assign rsp_valid       = chain_out[RULES-1].valid &&
                             (chain_out[RULES-1].item.mode == MODE_CLASSIFY);
    assign rsp.action      = chain_out[RULES-1].action;
    assign rsp.match_found = chain_out[RULES-1].found;
    assign rsp.hit_index   = chain_out[RULES-1].index;

endmodule

`default_nettype wire

>>> src/fmprc_cell.sv
// One classifier cell: holds one rule, matches a passing header and applies rule writes.
`timescale 1ns / 1ps
`default_nettype none

module fmprc_cell #(
    parameter int CellId = 0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          advance,
    input  wire [fmprc_pkg::COUNT_W-1:0] rule_count,
    input  fmprc_pkg::stage_t            stage_in,
    output fmprc_pkg::stage_t            stage_out
);
    import fmprc_pkg::*;

    // Only the first sixteen slots can be addressed by a write.
    localparam bit                    WRITABLE  = (CellId < 16);
    localparam logic [RULE_INDEX_W-1:0] CELL_IDX  = RULE_INDEX_W'(CellId);
    localparam bit                    COUNTABLE = (CellId < 31);
    localparam logic [COUNT_W-1:0]    CELL_CNT  = COUNT_W'(CellId);

    logic [CTRL_W-1:0] ctrl_reg;
    logic [WORD_W-1:0] addr_reg [4];
    logic              valid_reg;
    stage_t            data_reg;
    stage_t            data_next;

    // Control word fields.
    logic              rule_en;
    logic [1:0]        rule_fam;
    logic              rule_wild_proto;
    logic [7:0]        rule_proto;
    logic [7:0]        rule_src_len;
    logic [7:0]        rule_dst_len;
    logic [15:0]       rule_src_port;
    logic [15:0]       rule_dst_port;
    logic [ACTION_W-1:0] rule_action;

    logic              searched;
    logic              proto_ok;
    logic              fam_ok;
    logic              addr_ok;
    logic              port_ok;
    logic              hit;
    logic              write_here;

    assign rule_en         = ctrl_reg[0];
    assign rule_fam        = ctrl_reg[2:1];
    assign rule_wild_proto = ctrl_reg[3];
    assign rule_proto      = ctrl_reg[11:4];
    assign rule_src_len    = ctrl_reg[19:12];
    assign rule_dst_len    = ctrl_reg[27:20];
    assign rule_src_port   = ctrl_reg[43:28];
    assign rule_dst_port   = ctrl_reg[59:44];
    assign rule_action     = ctrl_reg[61:60];

    // Match checks against the header arriving at this cell.
    always_comb
    begin
        searched = COUNTABLE && (rule_count > CELL_CNT);
        proto_ok = rule_wild_proto || (rule_proto == stage_in.item.protocol);
        priority if (rule_fam == FAM_IPV4) begin
            fam_ok = (stage_in.item.pkt_version == IP_VER_4);
        end else if (rule_fam == FAM_IPV6) begin
            fam_ok = (stage_in.item.pkt_version == IP_VER_6);
        end else begin
            fam_ok = 1'b1;
        end
        addr_ok = (rule_fam == FAM_ANY) ||
                  (((({stage_in.item.src_addr_hi, stage_in.item.src_addr_lo} ^
                      {addr_reg[0], addr_reg[1]}) & prefix_mask(rule_src_len)) == '0) &&
                   ((({stage_in.item.dst_addr_hi, stage_in.item.dst_addr_lo} ^
                      {addr_reg[2], addr_reg[3]}) & prefix_mask(rule_dst_len)) == '0));
        port_ok = ((rule_src_port == 16'd0) || (rule_src_port == stage_in.item.src_port_in)) &&
                  ((rule_dst_port == 16'd0) || (rule_dst_port == stage_in.item.dst_port_in));
        hit = stage_in.valid && (stage_in.item.mode == MODE_CLASSIFY) && !stage_in.found &&
              searched && rule_en && proto_ok && fam_ok && addr_ok && port_ok;
    end

    // Pass the request on, recording the first hit.
    always_comb
    begin
        data_next = stage_in;
        if (hit) begin
            data_next.found  = 1'b1;
            data_next.action = rule_action;
            data_next.index  = CELL_IDX;
        end
    end

    assign write_here = advance && stage_in.valid && (stage_in.item.mode == MODE_WRITE) &&
                        WRITABLE && (stage_in.item.rule_index == CELL_IDX);

    // Stage register toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    // Control word; reset leaves the rule disabled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctrl_reg <= '0;
        end else if (write_here && (stage_in.item.word_select == WSEL_CTRL)) begin
            ctrl_reg <= stage_in.item.word_data[CTRL_W-1:0];
        end
    end

    // Address words need no reset.
    always_ff @(posedge clk)
    begin
        if (write_here) begin
            unique case (stage_in.item.word_select)
                WSEL_SRC_HI, WSEL_SRC_LO, WSEL_DST_HI, WSEL_DST_LO:
                begin
                    addr_reg[stage_in.item.word_select[1:0]] <= stage_in.item.word_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

>>> src/fmprc_checker.sv
// Port-level checks for the classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fmprc_checker #(
    parameter int RULES = fmprc_pkg::RULES_DEFAULT
) (
    input wire             clk,
    input wire             rst_n,
    input wire             req_valid,
    input wire             req_stall,
    input fmprc_pkg::req_t req,
    input wire             rsp_valid,
    input wire             rsp_stall,
    input fmprc_pkg::rsp_t rsp
);
    import fmprc_pkg::*;

    // A held response keeps its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("held response changed");

    // New requests stall exactly while a response is held.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("request stall does not follow response stall");

    // A default response reports index zero.
    a_default_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.match_found |-> rsp.hit_index == '0)
        else $error("default response with nonzero index");

    // A matched rule lies inside the table.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.match_found |-> 32'(rsp.hit_index) < RULES)
        else $error("match index beyond table");

endmodule

bind first_match_packet_rule_classifier fmprc_checker #(.RULES(RULES)) u_fmprc_checker (.*);

`default_nettype wire
